// File: rtl/core/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants for the min-heap priority queue: field widths, default
// sizes, command codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int KEY_W         = 32;
    localparam int DEF_DEPTH     = 1024;
    localparam int DEF_TAG_WIDTH = 16;
    localparam int STATUS_W      = 2;

    // command codes carried in tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

endpackage : mhpq_pkg

`default_nettype wire

// File: rtl/core/min_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of {signed key, tag} entries held in one synchronous RAM,
// with insert and pop-minimum requests and one result per request.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tuser: command; tdata: key, tag
//  m_axis   | out | m_axis_tvalid/tready    | tdata: key, tag, status,
//           |     |                         |        now_empty, entry_count
//  cfg      | in  | i_cfg_we                | i_cfg_wdata: capacity_limit
//
//  one request at a time. insert writes straight into an empty heap, else it
//  reads the parent and moves it down level by level while the entry rises;
//  pop reads the root and the last entry together and, unless that was the
//  only entry, sinks the moved entry level by level. each level is a read,
//  compare and write-back around the registered RAM read. a finished result
//  waits in the output register while the next request is taken; a request
//  ends only once that register is free.
//  reset is synchronous, clears the count and returns the capacity to DEPTH;
//  the RAM is not cleared since only entries below the count are ever used.
//
`default_nettype none

module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int DEPTH     = DEF_DEPTH,
    parameter int TAG_WIDTH = DEF_TAG_WIDTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int IN_W  = ((KEY_W + TAG_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((KEY_W + TAG_WIDTH + STATUS_W + 1 + CW + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration
    input  wire logic             i_cfg_we,
    input  wire logic [CW-1:0]    i_cfg_wdata,      // capacity_limit
    // request stream
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,     // key_in, tag_in
    input  wire logic             s_axis_tuser,     // command
    // result stream
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata      // key_out, tag_out, status,
                                                    // now_empty, entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int EW = KEY_W + TAG_WIDTH;
    localparam int LW = AW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_WR,
        ST_DN_LOAD,
        ST_DN,
        ST_FIN
    } t_state;

    function automatic logic key_less(input logic [EW-1:0] a, input logic [EW-1:0] b);
        return $signed(a[EW-1:TAG_WIDTH]) < $signed(b[EW-1:TAG_WIDTH]);
    endfunction

    // heap storage, entry = {key, tag}
    logic [EW-1:0] r_heap_mem [DEPTH];
    logic [EW-1:0] r_rd_a;
    logic [EW-1:0] r_rd_b;

    logic          mem_re;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cap;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_pos, n_pos;
    logic [EW-1:0]        r_cur, n_cur;
    logic [KEY_W-1:0]     r_key_o, n_key_o;
    logic [TAG_WIDTH-1:0] r_tag_o, n_tag_o;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic                 r_m_valid;
    logic [OUT_W-1:0]     r_m_data;

    logic [CW-1:0] cap_eff;
    logic          accept;
    logic          out_free;
    logic [EW-1:0] in_entry;
    logic [AW-1:0] ins_pos;
    logic [AW-1:0] up_par;
    logic [LW-1:0] lft_idx;
    logic [LW-1:0] rgt_idx;
    logic          lft_ok;
    logic          rgt_ok;
    logic          take_l;
    logic          take_r;
    logic [AW-1:0] child;
    logic [EW-1:0] child_data;

    assign cap_eff  = (r_cap > CW'(DEPTH)) ? CW'(DEPTH) : r_cap;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign in_entry = {s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W+TAG_WIDTH-1:KEY_W]};
    assign ins_pos  = r_count[AW-1:0];

    assign up_par   = AW'((r_pos - AW'(1)) >> 1);
    assign lft_idx  = LW'({r_pos, 1'b1});
    assign rgt_idx  = lft_idx + LW'(1);
    assign lft_ok   = lft_idx < LW'(r_count);
    assign rgt_ok   = rgt_idx < LW'(r_count);

    // left child checked first, right replaces only when strictly smaller
    always_comb begin
        take_l = lft_ok && key_less(r_rd_a, r_cur);
        take_r = 1'b0;
        if (rgt_ok) begin
            if (take_l) begin
                take_r = key_less(r_rd_b, r_rd_a);
            end else begin
                take_r = key_less(r_rd_b, r_cur);
            end
        end
        if (take_r) begin
            child      = rgt_idx[AW-1:0];
            child_data = r_rd_b;
        end else begin
            child      = lft_idx[AW-1:0];
            child_data = r_rd_a;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_key_o   = r_key_o;
        n_tag_o   = r_tag_o;
        n_status  = r_status;
        mem_re    = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        mem_we    = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_cur;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_key_o  = '0;
                    n_tag_o  = '0;
                    n_status = STAT_OK;
                    if (s_axis_tuser == CMD_INSERT) begin
                        if (r_count >= cap_eff) begin
                            n_status = STAT_OVERFLOW;
                            n_state  = ST_FIN;
                        end else begin
                            n_cur   = in_entry;
                            n_pos   = ins_pos;
                            n_count = r_count + CW'(1);
                            if (r_count == '0) begin
                                mem_we  = 1'b1;
                                wr_addr = '0;
                                wr_data = in_entry;
                                n_state = ST_FIN;
                            end else begin
                                mem_re    = 1'b1;
                                rd_addr_a = AW'((ins_pos - AW'(1)) >> 1);
                                n_state   = ST_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STAT_UNDERFLOW;
                            n_state  = ST_FIN;
                        end else begin
                            // root and last entry in one read
                            mem_re    = 1'b1;
                            rd_addr_a = '0;
                            rd_addr_b = AW'(r_count - CW'(1));
                            n_state   = ST_DN_LOAD;
                        end
                    end
                end
            end

            ST_UP: begin
                mem_we = 1'b1;
                if (key_less(r_cur, r_rd_a)) begin
                    // parent moves down, entry keeps rising
                    wr_data = r_rd_a;
                    n_pos   = up_par;
                    if (up_par == '0) begin
                        n_state = ST_WR;
                    end else begin
                        mem_re    = 1'b1;
                        rd_addr_a = AW'((up_par - AW'(1)) >> 1);
                    end
                end else begin
                    n_state = ST_FIN;
                end
            end

            ST_WR: begin
                mem_we  = 1'b1;
                n_state = ST_FIN;
            end

            ST_DN_LOAD: begin
                n_key_o = r_rd_a[EW-1:TAG_WIDTH];
                n_tag_o = r_rd_a[TAG_WIDTH-1:0];
                n_cur   = r_rd_b;
                n_pos   = '0;
                n_count = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_state = ST_FIN;
                end else begin
                    mem_re    = 1'b1;
                    rd_addr_a = AW'(1);
                    rd_addr_b = AW'(2);
                    n_state   = ST_DN;
                end
            end

            ST_DN: begin
                mem_we = 1'b1;
                if (take_l || take_r) begin
                    wr_data   = child_data;
                    n_pos     = child;
                    mem_re    = 1'b1;
                    rd_addr_a = AW'({child, 1'b1});
                    rd_addr_b = AW'({child, 1'b1} + LW'(1));
                end else begin
                    n_state = ST_FIN;
                end
            end

            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cap     <= CW'(DEPTH);
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (r_state == ST_FIN && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_key_o  <= n_key_o;
        r_tag_o  <= n_tag_o;
        r_status <= n_status;
        if (r_state == ST_FIN && out_free) begin
            r_m_data <= OUT_W'({r_count, (r_count == '0), r_status, r_tag_o, r_key_o});
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_heap_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_a <= r_heap_mem[rd_addr_a];
            r_rd_b <= r_heap_mem[rd_addr_b];
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule : min_heap_priority_queue

`default_nettype wire

// File: rtl/core/mhpq_chk.sv
// ----------------------------------------------------------------------------
// mhpq_chk
// Port-level checks for the min-heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_chk
    import mhpq_pkg::*;
#(
    parameter int DEPTH     = DEF_DEPTH,
    parameter int TAG_WIDTH = DEF_TAG_WIDTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OUT_W = ((KEY_W + TAG_WIDTH + STATUS_W + 1 + CW + 7) / 8) * 8,
    localparam int ST_LO = KEY_W + TAG_WIDTH,
    localparam int EM_B  = ST_LO + STATUS_W,
    localparam int CN_LO = EM_B + 1
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0] o_stat;
    logic                o_empty;
    logic [CW-1:0]       o_count;

    assign o_stat  = m_axis_tdata[EM_B-1:ST_LO];
    assign o_empty = m_axis_tdata[EM_B];
    assign o_count = m_axis_tdata[CN_LO+CW-1:CN_LO];

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request in flight: no accept right after an accept
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (o_empty == (o_count == '0)) && (o_count <= CW'(DEPTH)))
        else $error("empty flag disagrees with count");

    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (o_stat == STAT_OK || o_stat == STAT_OVERFLOW
                           || o_stat == STAT_UNDERFLOW))
        else $error("bad status code");

    a_unf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (o_stat == STAT_UNDERFLOW) |->
            (o_count == '0) && (m_axis_tdata[ST_LO-1:0] == '0))
        else $error("underflow with entries or data");

endmodule : mhpq_chk

bind min_heap_priority_queue mhpq_chk #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
) u_mhpq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/sv/min_heap_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_test
// Self-checking bench for the min-heap priority queue. A queue-fed driver
// offers insert and pop requests, a clocked monitor keeps its own heap image
// to predict each result and checks every returned result field by field.
// Covers empty and full heaps, ties on equal keys, capacity settings from
// zero to the top of the register, and back-pressure on both streams.
// ----------------------------------------------------------------------------

module min_heap_priority_queue_test;

    import mhpq_pkg::*;

    localparam int DEPTH_TB    = DEF_DEPTH;
    localparam int TAG_W       = DEF_TAG_WIDTH;
    localparam int CNT_W       = $clog2(DEPTH_TB + 1);
    localparam int IN_W        = ((KEY_W + TAG_W + 7) / 8) * 8;
    localparam int RES_W       = KEY_W + TAG_W + STATUS_W + 1 + CNT_W;
    localparam int OUT_W       = ((RES_W + 7) / 8) * 8;
    localparam int SETTLE      = 20;
    localparam int QUIET_LIMIT = 3000;

    typedef struct {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_heap_cmd;

    // same layout as the result tdata, lowest field last
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic                    empty;
        logic [STATUS_W-1:0]     status;
        logic [TAG_W-1:0]        tag;
        logic signed [KEY_W-1:0] key;
    } t_heap_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;     // key_in, tag_in
    logic             s_axis_tuser = 1'b0;   // command
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;          // key_out, tag_out, status, now_empty, entry_count

    min_heap_priority_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predicted heap image
    logic signed [KEY_W-1:0] heap_key [DEPTH_TB];
    logic [TAG_W-1:0]        heap_tag [DEPTH_TB];
    int                      heap_fill;
    logic [CNT_W-1:0]        cap_reg;

    t_heap_cmd    cmd_q [$];
    t_heap_result heap_result_q [$];
    t_heap_cmd    cur_cmd;
    t_heap_result got, want;

    logic req_taken = 1'b0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   stall_len = 0;
    int   stall_go = 0;
    int   stall_seen = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    int   err_count = 0;
    int   n_insert = 0;
    int   n_pop = 0;
    int   n_overflow = 0;
    int   n_underflow = 0;
    int   peak_fill = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void exchange_slots(input int a, input int b);
        logic signed [KEY_W-1:0] tk;
        logic [TAG_W-1:0]        tt;
        tk = heap_key[a];
        tt = heap_tag[a];
        heap_key[a] = heap_key[b];
        heap_tag[a] = heap_tag[b];
        heap_key[b] = tk;
        heap_tag[b] = tt;
    endfunction

    function automatic t_heap_result heap_exec(input t_heap_cmd c);
        t_heap_result r;
        int lim, pos, up, lc, rc, best;
        r = '0;
        lim = (cap_reg > DEPTH_TB) ? DEPTH_TB : int'(cap_reg);
        if (c.cmd == CMD_INSERT) begin
            if (heap_fill >= lim) begin
                r.status = STAT_OVERFLOW;
            end else begin
                pos = heap_fill;
                heap_key[pos] = c.key;
                heap_tag[pos] = c.tag;
                heap_fill++;
                // rise only past a strictly greater parent
                while (pos != 0) begin
                    up = (pos - 1) / 2;
                    if (!(heap_key[pos] < heap_key[up])) break;
                    exchange_slots(pos, up);
                    pos = up;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = STAT_UNDERFLOW;
            end else begin
                r.key = heap_key[0];
                r.tag = heap_tag[0];
                heap_key[0] = heap_key[heap_fill-1];
                heap_tag[0] = heap_tag[heap_fill-1];
                heap_fill--;
                pos = 0;
                forever begin
                    lc = 2 * pos + 1;
                    rc = lc + 1;
                    best = pos;
                    if (lc < heap_fill && heap_key[lc] < heap_key[best]) best = lc;
                    if (rc < heap_fill && heap_key[rc] < heap_key[best]) best = rc;
                    if (best == pos) break;
                    exchange_slots(pos, best);
                    pos = best;
                end
            end
        end
        r.empty = (heap_fill == 0);
        r.count = CNT_W'(heap_fill);
        return r;
    endfunction

    function automatic t_heap_cmd make_cmd(input int pop_pct);
        t_heap_cmd c;
        c.cmd = ($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_INSERT;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: c.key = 32'sh8000_0000;
                    1: c.key = 32'sh7fff_ffff;
                    2: c.key = '0;
                    default: c.key = '1;
                endcase
            end
            // narrow key range so equal keys meet often
            1, 2: c.key = $signed($urandom_range(0, 8)) - 4;
            default: c.key = $urandom;
        endcase
        c.tag = TAG_W'($urandom_range(0, 16'hffff));
        return c;
    endfunction

    task automatic add_cmd(input logic cmd, input logic signed [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag);
        t_heap_cmd c;
        c.cmd = cmd;
        c.key = key;
        c.tag = tag;
        cmd_q.push_back(c);
    endtask

    task automatic add_mix(input int n, input int pop_pct);
        for (int i = 0; i < n; i++) cmd_q.push_back(make_cmd(pop_pct));
    endtask

    task automatic wait_drained;
        do @(posedge i_clk);
        while (cmd_q.size() != 0 || s_axis_tvalid || heap_result_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                cur_cmd = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cur_cmd.cmd;
                s_axis_tdata  <= {cur_cmd.tag, cur_cmd.key};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with an optional long hold-off
    always @(negedge i_clk) begin
        if (stall_go != stall_seen) begin
            stall_seen = stall_go;
            stall_left = stall_len;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // prediction on each request, checking on each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            heap_fill    = 0;
            cap_reg      = CNT_W'(DEPTH_TB);
            quiet_cycles = 0;
            req_taken   <= 1'b0;
        end else begin
            if (i_cfg_we) cap_reg = i_cfg_wdata;
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                want = heap_exec('{cmd: s_axis_tuser,
                                   key: s_axis_tdata[KEY_W-1:0],
                                   tag: s_axis_tdata[KEY_W +: TAG_W]});
                heap_result_q.push_back(want);
                if (s_axis_tuser == CMD_INSERT) n_insert++;
                else n_pop++;
                if (want.status == STAT_OVERFLOW) n_overflow++;
                if (want.status == STAT_UNDERFLOW) n_underflow++;
                if (heap_fill > peak_fill) peak_fill = heap_fill;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_heap_result'(m_axis_tdata[RES_W-1:0]);
                if (heap_result_q.size() == 0) begin
                    $display("%0t: result with no request pending: %h", $time, m_axis_tdata);
                    err_count++;
                end else begin
                    want = heap_result_q.pop_front();
                    if (got.key !== want.key) begin
                        $display("%0t: key_out expected %0d got %0d", $time, want.key, got.key);
                        err_count++;
                    end
                    if (got.tag !== want.tag) begin
                        $display("%0t: tag_out expected %h got %h", $time, want.tag, got.tag);
                        err_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, got.status);
                        err_count++;
                    end
                    if (got.empty !== want.empty) begin
                        $display("%0t: now_empty expected %b got %b", $time,
                                 want.empty, got.empty);
                        err_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: entry_count expected %0d got %0d", $time,
                                 want.count, got.count);
                        err_count++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        tx_idle_pct = 14;
        rx_idle_pct = 78;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // empty pop, extreme keys and tags, equal keys, drain to empty
        write_capacity(CNT_W'(DEPTH_TB));
        add_cmd(CMD_POP,    32'sh1234_5678, 16'hffff);
        add_cmd(CMD_INSERT, 32'sh7fff_ffff, 16'hffff);
        add_cmd(CMD_INSERT, 32'sh8000_0000, 16'h0000);
        add_cmd(CMD_INSERT, 0,  16'h0001);
        add_cmd(CMD_INSERT, -1, 16'h0002);
        add_cmd(CMD_INSERT, 1,  16'h0003);
        add_cmd(CMD_INSERT, 5,  16'h00aa);
        add_cmd(CMD_INSERT, 5,  16'h0055);
        add_cmd(CMD_INSERT, 5,  16'h1234);
        add_cmd(CMD_INSERT, -1, 16'h0004);
        for (int i = 0; i < 10; i++) add_cmd(CMD_POP, '1, 16'hffff);
        wait_drained();

        // zero capacity refuses every insert
        write_capacity('0);
        add_cmd(CMD_INSERT, 7, 16'h0007);
        add_cmd(CMD_INSERT, 32'sh8000_0000, 16'hffff);
        add_cmd(CMD_POP, 0, 16'h0000);
        wait_drained();

        write_capacity(CNT_W'(1));
        add_cmd(CMD_INSERT, 3, 16'h0003);
        add_cmd(CMD_INSERT, -3, 16'h0004);
        add_cmd(CMD_POP, 0, 16'h0000);
        add_cmd(CMD_POP, 0, 16'h0000);
        wait_drained();

        // small capacities, first setting under a long receiver hold-off
        for (int ph = 0; ph < 4; ph++) begin
            write_capacity(CNT_W'($urandom_range(2, 48)));
            if (ph == 0) begin
                stall_len = 300;
                stall_go++;
            end
            add_mix(25, 45);
            wait_drained();
        end

        // capacity above depth saturates: fill the whole store, then overflow
        tx_idle_pct = 78;
        rx_idle_pct = 14;
        write_capacity('1);
        add_mix(DEPTH_TB - heap_fill + 3, 0);
        add_mix(30, 50);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_capacity(CNT_W'(DEPTH_TB));
        add_mix(30, 50);
        wait_drained();

        // capacity below the current fill: inserts refused, pops go on
        write_capacity(CNT_W'(3));
        add_mix(30, 50);
        wait_drained();

        write_capacity(CNT_W'($urandom_range(1, DEPTH_TB)));
        add_mix(30, 50);
        wait_drained();

        $display("covered %0d requests: %0d inserts, %0d pops, %0d overflows, %0d underflows",
                 n_insert + n_pop, n_insert, n_pop, n_overflow, n_underflow);
        $display("capacity from zero to the register top, peak fill %0d of %0d",
                 peak_fill, DEPTH_TB);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
